// ===== rtl/drp_pkg.sv =====
package drp_pkg;

    // Result codes carried in the status field.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_TEMPERATURE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMPERATURE = 8'd1;

    // Reset values of the temperature limits.
    localparam logic [7:0] MIN_TEMPERATURE_RESET = 8'd50;
    localparam logic [7:0] MAX_TEMPERATURE_RESET = 8'd150;

    // Character codes used by the parser.
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  temperature;
        logic [31:0] seconds;
        logic        motor_on;
    } out_beat_t;

endpackage

// ===== rtl/drp_parser.sv =====
module drp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  drp_pkg::in_beat_t  beat,
    input  logic [7:0]         min_temperature,
    input  logic [7:0]         max_temperature,
    output drp_pkg::out_beat_t result
);
    import drp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_TEMP  = 3'd1,
        PH_SLASH = 3'd2,
        PH_SECS  = 3'd3,
        PH_TRAIL = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  temp_reg, temp_next;
    logic [31:0] secs_reg, secs_next;
    logic        err_reg, err_next;
    logic        ovf_reg, ovf_next;

    logic        is_bad;
    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [11:0] temp_mac;
    logic [35:0] secs_mac;

    // Character classes of the current byte.
    assign is_bad   = (beat.char_byte == 8'h00) || beat.char_byte[7];
    assign is_digit = (beat.char_byte >= CHAR_ZERO) && (beat.char_byte <= CHAR_NINE);
    assign is_space = (beat.char_byte == CHAR_SPACE) ||
                      ((beat.char_byte >= CHAR_TAB) && (beat.char_byte <= CHAR_CR));
    assign digit    = beat.char_byte[3:0];

    // Multiply-by-ten accumulate, built from two shifts and two adds.
    assign temp_mac = ({4'd0, temp_reg} << 3) + ({4'd0, temp_reg} << 1) + {8'd0, digit};
    assign secs_mac = ({4'd0, secs_reg} << 3) + ({4'd0, secs_reg} << 1) + {32'd0, digit};

    // Next parse state for the current byte.
    always_comb
    begin
        phase_next = phase_reg;
        temp_next  = temp_reg;
        secs_next  = secs_reg;
        err_next   = err_reg;
        ovf_next   = ovf_reg;
        if (!err_reg)
        begin
            if (is_bad)
            begin
                err_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_TEMP;
                            temp_next  = {4'd0, digit};
                        end
                        else if (!is_space)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_TEMP:
                    begin
                        if (is_digit)
                        begin
                            temp_next = (temp_mac[11:8] != 4'd0) ? 8'hFF : temp_mac[7:0];
                        end
                        else if (beat.char_byte == CHAR_SLASH)
                        begin
                            phase_next = PH_SLASH;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_SLASH:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_SECS;
                            secs_next  = {28'd0, digit};
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_SECS:
                    begin
                        if (is_digit)
                        begin
                            if (secs_mac[35:32] != 4'd0)
                            begin
                                ovf_next  = 1'b1;
                                secs_next = 32'hFFFF_FFFF;
                            end
                            else
                            begin
                                secs_next = secs_mac[31:0];
                            end
                        end
                        else if (is_space)
                        begin
                            phase_next = PH_TRAIL;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (!is_space)
                        begin
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // Judge the message as it stands after this byte.
    always_comb
    begin
        result.temperature = temp_next;
        result.seconds     = secs_next;
        if (err_next)
        begin
            result.status      = ST_SYNTAX;
            result.temperature = 8'd0;
            result.seconds     = 32'd0;
        end
        else if ((temp_next < min_temperature) || (temp_next > max_temperature))
        begin
            result.status = ST_RANGE;
        end
        else if (ovf_next)
        begin
            result.status = ST_OVERFLOW;
        end
        else
        begin
            result.status = ST_OK;
        end
        result.motor_on = (result.status == ST_OK) && (result.seconds != 32'd0);
    end

    // Parse state; the last byte of a message returns it to the start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            temp_reg  <= 8'd0;
            secs_reg  <= 32'd0;
            err_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (beat.last_byte)
            begin
                phase_reg <= PH_LEAD;
                temp_reg  <= 8'd0;
                secs_reg  <= 32'd0;
                err_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                temp_reg  <= temp_next;
                secs_reg  <= secs_next;
                err_reg   <= err_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// ===== rtl/dry_request_parser.sv =====
// Dry request parser: takes a command message of the form
// "[spaces] temperature/seconds [spaces]" one ASCII byte per beat.
// Input channel: in_valid, in_stall, in_data (char_byte, last_byte).
// Output channel: out_valid, out_stall, out_data (status, temperature,
// seconds, motor_on); one result beat is given per message, for the byte
// marked last_byte.
// Configuration: cfg_valid, cfg_ready, cfg_index, cfg_data write the
// minimum (index 0) and maximum (index 1) temperature; cfg_ready is
// always high. Other indexes are ignored. Write only while idle.
// Throughput is one byte per cycle while in_stall is low, set by the
// combinational parse step (multiply-by-ten accumulate) between the
// input and result registers. A last byte's result is registered in
// the result register, driving out_valid, once that register is free.
// When the receiver stalls, the result is held; non-final bytes keep
// flowing, and a following last byte waits in the input register,
// which then raises in_stall until the result beat is taken.
// Reset clears the parse state and the valid bits of both registers; the
// limits return to 50 and 150 degrees.
module dry_request_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  drp_pkg::in_beat_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output drp_pkg::out_beat_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [drp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);
    import drp_pkg::*;

    logic       in_valid_reg;
    in_beat_t   in_beat_reg;
    logic       out_valid_reg;
    out_beat_t  out_beat_reg;
    logic [7:0] min_temp_reg;
    logic [7:0] max_temp_reg;

    logic       res_free;
    logic       go;
    logic       in_fire;
    out_beat_t  result;

    // Handshake: the input register moves on unless it holds a last byte
    // and the result register is still occupied.
    assign res_free  = !out_valid_reg || !out_stall;
    assign go        = in_valid_reg && (!in_beat_reg.last_byte || res_free);
    assign in_stall  = in_valid_reg && !go;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    drp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (go),
        .beat            (in_beat_reg),
        .min_temperature (min_temp_reg),
        .max_temperature (max_temp_reg),
        .result          (result)
    );

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_temp_reg  <= MIN_TEMPERATURE_RESET;
            max_temp_reg  <= MAX_TEMPERATURE_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end

            if (go && in_beat_reg.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MIN_TEMPERATURE: min_temp_reg <= cfg_data;
                    REG_MAX_TEMPERATURE: max_temp_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_beat_reg <= in_data;
        end
        if (go && in_beat_reg.last_byte)
        begin
            out_beat_reg <= result;
        end
    end

endmodule

// ===== rtl/drp_checker.sv =====
module drp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input drp_pkg::out_beat_t out_data
);
    import drp_pkg::*;

    // A stalled result beat stays up and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // A syntax error result carries zero temperature and seconds.
    a_syntax_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_SYNTAX) |->
            (out_data.temperature == 8'd0) && (out_data.seconds == 32'd0))
        else $error("syntax error result carries nonzero fields");

    // The motor runs only for an accepted request with nonzero seconds.
    a_motor_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.motor_on |->
            (out_data.status == ST_OK) && (out_data.seconds != 32'd0))
        else $error("motor on without an accepted nonzero duration");

    // An accepted request with nonzero seconds turns the motor on.
    a_motor_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OK) && (out_data.seconds != 32'd0) |->
            out_data.motor_on)
        else $error("motor off for an accepted nonzero duration");

endmodule

bind dry_request_parser drp_checker u_drp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
